### rtl/utf16_to_utf8_encoder_assert.svh
// ============================================================================
// UTF-16 to UTF-8 encoder assertion macros
// Shared property macros for the concurrent checks in the encoder modules.
// ============================================================================
`ifndef UTF16_TO_UTF8_ENCODER_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U2U_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define U2U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder check failed");

`endif

### rtl/utf8e_pkg.sv
// ============================================================================
// utf8e_pkg
// Types, constants and the BMP encoding function shared by the encoder.
// ============================================================================
`default_nettype none

package utf8e_pkg;

    // Surrogate ranges.
    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    // Encoded length limits.
    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

    // Lead and continuation byte markers.
    localparam logic [2:0] LEAD2_MARK = 3'b110;
    localparam logic [3:0] LEAD3_MARK = 4'b1110;
    localparam logic [4:0] LEAD4_MARK = 5'b11110;
    localparam logic [1:0] CONT_MARK  = 2'b10;

    // Most bytes one request can cause.
    localparam int MAX_BYTES = 6;

    // Input request.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        stream_end;
    } unit_t;

    // Output request.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_last;
    } byte_t;

    // One classified request: the bytes it causes, first byte at index 0.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      text_end;
    } job_t;

    // Encoding of one code point from the basic plane.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      len;
    } bmp_enc_t;

    function automatic bmp_enc_t enc_bmp(input logic [15:0] u);
        bmp_enc_t e;
        e = '0;
        if (u < ONE_BYTE_LIMIT) begin
            e.bytes[0] = u[7:0];
            e.len      = 2'd1;
        end
        else if (u < TWO_BYTE_LIMIT) begin
            e.bytes[0] = {LEAD2_MARK, u[10:6]};
            e.bytes[1] = {CONT_MARK, u[5:0]};
            e.len      = 2'd2;
        end
        else begin
            e.bytes[0] = {LEAD3_MARK, u[15:12]};
            e.bytes[1] = {CONT_MARK, u[11:6]};
            e.bytes[2] = {CONT_MARK, u[5:0]};
            e.len      = 2'd3;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

### rtl/utf8e_front.sv
// ============================================================================
// utf8e_front
// Accepts code units, pairs surrogates and builds the byte list per request.
// ============================================================================
`default_nettype none

module utf8e_front
    import utf8e_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  unit_valid,
    output logic       unit_ready,
    input  wire unit_t unit_data,
    output logic       push_valid,
    input  wire logic  push_ready,
    output job_t       push_job
);

    logic [15:0] held_high_reg, held_high_next;
    logic        held_valid_reg, held_valid_next;

    logic       is_high;
    logic       is_low;
    logic       pair;
    logic       emit_unit;
    logic       accept;
    logic [4:0] plane;
    bmp_enc_t   unit_enc;
    bmp_enc_t   held_enc;
    job_t       job;

    // Classify the incoming unit.
    always_comb
    begin
        is_high   = unit_data.code_unit inside {[HIGH_FIRST:HIGH_LAST]};
        is_low    = unit_data.code_unit inside {[LOW_FIRST:LOW_LAST]};
        pair      = held_valid_reg && is_low;
        emit_unit = !(is_high && !unit_data.stream_end);
        unit_enc  = enc_bmp(unit_data.code_unit);
        held_enc  = enc_bmp(held_high_reg);
        plane     = {1'b0, held_high_reg[9:6]} + 5'd1;
    end

    // Build the list of bytes this request causes.
    always_comb
    begin
        job          = '0;
        job.text_end = unit_data.stream_end;
        if (pair) begin
            job.bytes[0] = {LEAD4_MARK, plane[4:2]};
            job.bytes[1] = {CONT_MARK, plane[1:0], held_high_reg[5:2]};
            job.bytes[2] = {CONT_MARK, held_high_reg[1:0], unit_data.code_unit[9:6]};
            job.bytes[3] = {CONT_MARK, unit_data.code_unit[5:0]};
            job.count    = 3'd4;
        end
        else if (held_valid_reg) begin
            job.bytes[0] = held_enc.bytes[0];
            job.bytes[1] = held_enc.bytes[1];
            job.bytes[2] = held_enc.bytes[2];
            job.bytes[3] = unit_enc.bytes[0];
            job.bytes[4] = unit_enc.bytes[1];
            job.bytes[5] = unit_enc.bytes[2];
            job.count    = emit_unit ? (3'd3 + {1'b0, unit_enc.len}) : 3'd3;
        end
        else begin
            job.bytes[0] = unit_enc.bytes[0];
            job.bytes[1] = unit_enc.bytes[1];
            job.bytes[2] = unit_enc.bytes[2];
            job.count    = emit_unit ? {1'b0, unit_enc.len} : 3'd0;
        end
    end

    // A request that only stores a high surrogate sends nothing onward.
    assign unit_ready = push_ready;
    assign accept     = unit_valid && push_ready;
    assign push_valid = unit_valid && (job.count != 3'd0);
    assign push_job   = job;

    // Held surrogate update.
    always_comb
    begin
        held_high_next  = held_high_reg;
        held_valid_next = held_valid_reg;
        if (accept) begin
            if (unit_data.stream_end) begin
                held_high_next  = '0;
                held_valid_next = 1'b0;
            end
            else if (pair) begin
                held_valid_next = 1'b0;
            end
            else if (is_high) begin
                held_high_next  = unit_data.code_unit;
                held_valid_next = 1'b1;
            end
            else begin
                held_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_high_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else begin
            held_high_reg  <= held_high_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/utf8e_queue.sv
// ============================================================================
// utf8e_queue
// Short first-in first-out queue of classified requests.
// ============================================================================
`default_nettype none
`include "utf16_to_utf8_encoder_assert.svh"

module utf8e_queue
    import utf8e_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    // The fill level never passes the depth.
    `U2U_ASSERT_NOW(a_level_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    // A lone push raises the level by one.
    `U2U_ASSERT_NEXT(a_push_level, clk, rst_n, push && !pop,
                     count_reg == $past(count_reg) + 1'b1)
    // A lone pop lowers the level by one.
    `U2U_ASSERT_NEXT(a_pop_level, clk, rst_n, pop && !push,
                     count_reg == $past(count_reg) - 1'b1)
    // The front never queues a request without bytes.
    `U2U_ASSERT_NOW(a_push_nonempty, clk, rst_n, push, push_job.count != 3'd0)

endmodule

`default_nettype wire

### rtl/utf8e_back.sv
// ============================================================================
// utf8e_back
// Sends queued bytes through a register, one per cycle unless stalled.
// ============================================================================
`default_nettype none
`include "utf16_to_utf8_encoder_assert.svh"

module utf8e_back
    import utf8e_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pop_valid,
    output logic      pop_ready,
    input  wire job_t pop_job,
    output logic      byte_valid,
    input  wire logic byte_ready,
    output byte_t     byte_data
);

    job_t       job_reg, job_next;
    logic       active_reg, active_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_data_reg, out_data_next;

    logic slot_free;
    logic emit;
    logic is_last;

    assign slot_free  = !out_valid_reg || byte_ready;
    assign emit       = active_reg && slot_free;
    assign is_last    = (idx_reg == job_reg.count - 3'd1);
    assign pop_ready  = !active_reg || (emit && is_last);
    assign byte_valid = out_valid_reg;
    assign byte_data  = out_data_reg;

    // Byte selection and job sequencing.
    always_comb
    begin
        job_next       = job_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next          = 1'b1;
            out_data_next.out_byte  = job_reg.bytes[idx_reg];
            out_data_next.run_last  = is_last;
            out_data_next.text_last = is_last && job_reg.text_end;
            idx_next                = idx_reg + 3'd1;
        end
        else if (byte_ready) begin
            out_valid_next = 1'b0;
        end
        if (pop_valid && pop_ready) begin
            job_next    = pop_job;
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (emit && is_last) begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_data_reg <= out_data_next;
    end

    // The byte index stays inside the current job.
    `U2U_ASSERT_NOW(a_idx_bound, clk, rst_n, active_reg, idx_reg < job_reg.count)
    // An active job carries between one and six bytes.
    `U2U_ASSERT_NOW(a_job_size, clk, rst_n, active_reg,
                    (job_reg.count != 3'd0) && (job_reg.count <= 3'd6))
    // The end of the text is always the end of a run.
    `U2U_ASSERT_NOW(a_text_in_run, clk, rst_n, out_valid_reg && out_data_reg.text_last,
                    out_data_reg.run_last)

endmodule

`default_nettype wire

### rtl/utf16_to_utf8_encoder.sv
// ============================================================================
// utf16_to_utf8_encoder
// Converts a stream of UTF-16 code units into UTF-8 bytes.
// ============================================================================
// Usage:
// The unit channel (unit_valid, unit_ready, unit_data) takes one UTF-16 code
// unit per request, with stream_end set on the last unit of a text. The byte
// channel (byte_valid, byte_ready, byte_data) gives one UTF-8 byte per
// request; run_last marks the last byte caused by a unit and text_last the
// final byte of the text.
// A high surrogate without stream_end is held until the next unit arrives
// and causes no bytes by itself; a pair then gives four bytes, an unpaired
// surrogate three. A taken unit passes through the queue, the back's job
// register and the output register. The output sends one byte per cycle
// while byte_ready is high, and a unit causes up to six bytes (usually one
// to three); units are taken every cycle while the request queue between
// the front and back has room.
// Reset clears the held surrogate, the queue level and the output valid flag.
// When the receiver stalls, the byte on the output holds and the queue
// fills; unit_ready falls once it is full.
// ============================================================================
`default_nettype none

module utf16_to_utf8_encoder
    import utf8e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  unit_valid,
    output logic       unit_ready,
    input  wire unit_t unit_data,
    output logic       byte_valid,
    input  wire logic  byte_ready,
    output byte_t      byte_data
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // Front: surrogate pairing and byte list.
    utf8e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_data  (unit_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Queue between the two halves.
    utf8e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back: byte serialiser.
    utf8e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data)
    );

endmodule

`default_nettype wire
